// File: rtl/lav_pkg.sv
// Shared constants, types and rounding helper for the look-at matrix pipeline.
package lav_pkg;

  // Unit vectors carry this many fraction bits.
  localparam int UNIT_FB   = 30;

  // Register stages of the pieces that make up one vector normalizer.
  localparam int MAG_LAT   = 1;
  localparam int NORM_LAT  = 3;
  localparam int SQ_LAT    = 2;
  localparam int SQRT_LAT  = 32;
  localparam int DIV_LAT   = 32;
  localparam int SIGN_LAT  = 1;
  localparam int UNIT_LAT  = MAG_LAT + NORM_LAT + SQ_LAT + SQRT_LAT + DIV_LAT + SIGN_LAT;

  localparam int CROSS_LAT = 2;
  localparam int TAIL_LAT  = 6;

  localparam int ELEM_W    = 40;

  typedef enum logic [1:0] {
    ROW_SIDE  = 2'd0,
    ROW_UP    = 2'd1,
    ROW_FWD   = 2'd2,
    ROW_CONST = 2'd3
  } row_idx_t;

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef struct packed {
    elem_t e3;
    elem_t e2;
    elem_t e1;
    elem_t e0;
  } row_t;

  typedef struct packed {
    row_t side;
    row_t up;
    row_t fwd;
    logic degen;
  } mat_t;

  // Round to nearest with ties away from zero while dropping sh fraction bits.
  function automatic logic signed [65:0] rnd_shift(input logic signed [65:0] v,
                                                  input int unsigned sh);
    logic [65:0] mag;
    logic [65:0] res;
    mag = v[65] ? $unsigned(-v) : $unsigned(v);
    res = (mag + (66'd1 << (sh - 1))) >> sh;
    return v[65] ? -$signed(res) : $signed(res);
  endfunction

endpackage

// File: rtl/look_at_view_matrix.sv
// Top level: look-at view matrix builder with a four-row output serializer.
// Throughput: the pipeline takes one word per cycle while the output register is free;
// each word leaves as four rows on one output channel, and the pipeline stalls while they go out.
// Reset (rst_n low, synchronous) clears all valid bits and the serializer; data is not reset.
module look_at_view_matrix import lav_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z (32 bits each)
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // elem0, elem1, elem2, elem3 (40 bits each)
  output logic [159:0] out_tdata,
  // row_index (2 bits), degenerate (1 bit)
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);

  localparam elem_t ONE_Q = ELEM_W'(64'd1 << FRAC_BITS);

  logic adv;

  logic               vld0_r;
  logic signed [31:0] eye0_r [3];
  logic signed [32:0] dir0_r [3];
  logic signed [31:0] up0_r  [3];

  logic               vld_f, ok_f, ok_up;
  logic signed [31:0] f [3];
  logic signed [31:0] un [3];

  logic               vldx1_r, vldx2_r;
  logic signed [63:0] fu_r [6];
  logic signed [63:0] sc_r [3];

  logic               vld_s, ok_s;
  logic signed [31:0] s [3];

  logic [95:0]        eye_dly;
  logic [96:0]        f_dly;
  logic signed [31:0] eye_t [3];
  logic signed [31:0] f_t [3];

  logic     tail_vld;
  mat_t     tail_mat;

  mat_t     mat_r;
  logic     full_r, full_nxt;
  row_idx_t row_r, row_nxt;
  row_t     row_sel;

  // The whole pipeline moves when the serializer can take a finished matrix.
  assign adv       = !full_r || (out_tready && row_r == ROW_CONST);
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r  <= 1'b0;
      vldx1_r <= 1'b0;
      vldx2_r <= 1'b0;
    end else if (adv) begin
      vld0_r  <= in_tvalid;
      vldx1_r <= vld_f;
      vldx2_r <= vldx1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 3; j++) begin
        eye0_r[j] <= $signed(in_tdata[32*j +: 32]);
        dir0_r[j] <= 33'($signed(in_tdata[32*(j+3) +: 32])) -
                     33'($signed(in_tdata[32*j +: 32]));
        up0_r[j]  <= $signed(in_tdata[32*(j+6) +: 32]);
      end
      fu_r[0] <= f[1] * un[2];
      fu_r[1] <= f[2] * un[1];
      fu_r[2] <= f[2] * un[0];
      fu_r[3] <= f[0] * un[2];
      fu_r[4] <= f[0] * un[1];
      fu_r[5] <= f[1] * un[0];
      for (int j = 0; j < 3; j++) begin
        sc_r[j] <= fu_r[2*j] - fu_r[2*j+1];
      end
    end
  end

  lav_unit #(.VW(33)) u_unit_fwd (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (vld0_r),
    .v_i   (dir0_r),
    .vld_o (vld_f),
    .ok_o  (ok_f),
    .u_o   (f)
  );

  lav_unit #(.VW(32)) u_unit_up (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (vld0_r),
    .v_i   (up0_r),
    .vld_o (),
    .ok_o  (ok_up),
    .u_o   (un)
  );

  lav_unit #(.VW(64)) u_unit_side (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (vldx2_r),
    .v_i   (sc_r),
    .vld_o (vld_s),
    .ok_o  (ok_s),
    .u_o   (s)
  );

  lav_delay #(.W(96), .D(2*UNIT_LAT + CROSS_LAT)) u_eye_dly (
    .clk (clk),
    .en  (adv),
    .d_i ({eye0_r[2], eye0_r[1], eye0_r[0]}),
    .q_o (eye_dly)
  );

  lav_delay #(.W(97), .D(CROSS_LAT + UNIT_LAT)) u_fwd_dly (
    .clk (clk),
    .en  (adv),
    .d_i ({ok_f && ok_up, f[2], f[1], f[0]}),
    .q_o (f_dly)
  );

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      eye_t[j] = $signed(eye_dly[32*j +: 32]);
      f_t[j]   = $signed(f_dly[32*j +: 32]);
    end
  end

  lav_tail #(.FRAC_BITS(FRAC_BITS)) u_tail (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (vld_s),
    .ok_i  (f_dly[96] && ok_s),
    .s_i   (s),
    .f_i   (f_t),
    .eye_i (eye_t),
    .vld_o (tail_vld),
    .mat_o (tail_mat)
  );

  // Output serializer: one matrix, sent as four words.
  always_comb begin
    full_nxt = full_r;
    row_nxt  = row_r;
    if (adv) begin
      full_nxt = tail_vld;
      row_nxt  = ROW_SIDE;
    end else if (out_tready) begin
      row_nxt = row_idx_t'(row_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      row_r  <= ROW_SIDE;
    end else begin
      full_r <= full_nxt;
      row_r  <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail_vld) begin
      mat_r <= tail_mat;
    end
  end

  always_comb begin
    row_sel = '0;
    unique case (row_r)
      ROW_SIDE:  row_sel = mat_r.side;
      ROW_UP:    row_sel = mat_r.up;
      ROW_FWD:   row_sel = mat_r.fwd;
      ROW_CONST: row_sel.e3 = ONE_Q;
      default:   row_sel = '0;
    endcase
  end

  assign out_tvalid = full_r;
  assign out_tdata  = {row_sel.e3, row_sel.e2, row_sel.e1, row_sel.e0};
  assign out_tuser  = {mat_r.degen, row_r};
  assign out_tlast  = (row_r == ROW_CONST);

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] && !out_tlast |-> out_tdata == '0)
    else $error("degenerate row carries nonzero elements");

  a_const_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[119:0] == '0 && out_tdata[159:120] == ONE_Q)
    else $error("constant row has wrong contents");

  a_rows_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("matrix rows interrupted before the last row");

endmodule

// File: rtl/lav_delay.sv
// Enabled shift line that carries side data alongside the pipeline.
module lav_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= d_i;
      for (int i = 1; i < D; i++) begin
        pipe_r[i] <= pipe_r[i-1];
      end
    end
  end

  assign q_o = pipe_r[D-1];

endmodule

// File: rtl/lav_norm.sv
// Block floating-point normalizer: scales three magnitudes so the largest sits in [2^30, 2^31).
module lav_norm #(
  parameter int W = 33
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         vld_i,
  input  logic [W-1:0] mag_i [3],
  output logic         vld_o,
  output logic [30:0]  mag_o [3]
);

  localparam int AW = $clog2(W + 1);
  localparam int EW = W + 31;

  logic [W-1:0]  orv;
  logic [AW-1:0] amt_nxt;
  logic          vld1_r, vld2_r, vld3_r;
  logic [AW-1:0] amt1_r;
  logic [2:0]    fine2_r;
  logic [EW-1:0] ext1_r [3];
  logic [EW-1:0] ext2_r [3];
  logic [30:0]   mag3_r [3];

  // The leading one of the OR is the leading one of the largest magnitude.
  // Placing the value 31 bits up turns every case into a right shift by msb+1.
  always_comb begin
    orv     = mag_i[0] | mag_i[1] | mag_i[2];
    amt_nxt = '0;
    for (int i = 0; i < W; i++) begin
      if (orv[i]) amt_nxt = AW'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      amt1_r  <= amt_nxt;
      fine2_r <= amt1_r[2:0];
      for (int j = 0; j < 3; j++) begin
        ext1_r[j] <= {mag_i[j], 31'b0};
        ext2_r[j] <= ext1_r[j] >> {amt1_r[AW-1:3], 3'b000};
        mag3_r[j] <= 31'(ext2_r[j] >> fine2_r);
      end
    end
  end

  assign vld_o = vld3_r;
  assign mag_o = mag3_r;

endmodule

// File: rtl/lav_isqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
module lav_isqrt import lav_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  logic [63:0] x_i,
  output logic        vld_o,
  output logic [31:0] root_o
);

  logic [33:0] rem_r  [SQRT_LAT];
  logic [31:0] root_r [SQRT_LAT];
  logic [63:0] x_r    [SQRT_LAT];
  logic        vld_r  [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_step
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] x_in;
    logic        vld_in;
    logic [35:0] cur;
    logic [35:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign x_in    = x_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    always_comb begin
      cur   = {rem_in, x_in[63:62]};
      trial = 36'({root_in, 2'b01});
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? 34'(cur - trial) : cur[33:0];
        root_r[k] <= {root_in[30:0], ge};
        x_r[k]    <= {x_in[61:0], 2'b00};
      end
    end
  end

  assign vld_o  = vld_r[SQRT_LAT-1];
  assign root_o = root_r[SQRT_LAT-1];

endmodule

// File: rtl/lav_div.sv
// Pipelined restoring divider: three rounded quotients m*2^30/n sharing one divisor.
module lav_div import lav_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  logic [31:0] n_i,
  input  logic [30:0] m_i [3],
  output logic        vld_o,
  output logic [30:0] q_o [3]
);

  localparam int STEPS = DIV_LAT - 1;

  logic        vld0_r;
  logic [31:0] n0_r;
  logic [61:0] num0_r [3];

  logic        vld_r  [STEPS];
  logic [31:0] n_r    [STEPS];
  logic [31:0] rem_r  [STEPS][3];
  logic [30:0] low_r  [STEPS][3];
  logic [30:0] q_r    [STEPS][3];

  // Adding half the divisor up front makes the truncating quotient a rounded one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n0_r <= n_i;
      for (int j = 0; j < 3; j++) begin
        num0_r[j] <= {m_i[j], 30'b0} + 62'(n_i[31:1]);
      end
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic        vld_in;
    logic [31:0] n_in;
    logic [31:0] rem_in [3];
    logic [30:0] low_in [3];
    logic [30:0] q_in   [3];
    logic [32:0] cur    [3];
    logic        ge     [3];

    if (k == 0) begin : g_first
      assign vld_in = vld0_r;
      assign n_in   = n0_r;
      for (genvar j = 0; j < 3; j++) begin : g_lane
        // The quotient fits in 31 bits, so the top part is already below n.
        assign rem_in[j] = {1'b0, num0_r[j][61:31]};
        assign low_in[j] = num0_r[j][30:0];
        assign q_in[j]   = '0;
      end
    end else begin : g_next
      assign vld_in = vld_r[k-1];
      assign n_in   = n_r[k-1];
      for (genvar j = 0; j < 3; j++) begin : g_lane
        assign rem_in[j] = rem_r[k-1][j];
        assign low_in[j] = low_r[k-1][j];
        assign q_in[j]   = q_r[k-1][j];
      end
    end

    always_comb begin
      for (int j = 0; j < 3; j++) begin
        cur[j] = {rem_in[j], low_in[j][30]};
        ge[j]  = (cur[j] >= 33'(n_in));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k] <= n_in;
        for (int j = 0; j < 3; j++) begin
          rem_r[k][j] <= ge[j] ? 32'(cur[j] - 33'(n_in)) : cur[j][31:0];
          low_r[k][j] <= {low_in[j][29:0], 1'b0};
          q_r[k][j]   <= {q_in[j][29:0], ge[j]};
        end
      end
    end
  end

  assign vld_o = vld_r[STEPS-1];
  assign q_o   = q_r[STEPS-1];

endmodule

// File: rtl/lav_unit.sv
// Vector normalizer: turns a signed 3-vector into a unit vector with 30 fraction bits.
module lav_unit import lav_pkg::*; #(
  parameter int VW = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic signed [VW-1:0] v_i [3],
  output logic                 vld_o,
  output logic                 ok_o,
  output logic signed [31:0]   u_o [3]
);

  logic          vld_mag_r;
  logic [VW-1:0] mag_r [3];
  logic [2:0]    sgn_r;
  logic          zero_r;

  logic          vld_norm;
  logic [30:0]   mn [3];
  logic          vld_sq_r, vld_sum_r;
  logic [61:0]   sq_r [3];
  logic [63:0]   sum_r;
  logic          vld_root;
  logic [31:0]   root;
  logic [92:0]   mn_dly;
  logic [30:0]   mdiv [3];
  logic          vld_q;
  logic [30:0]   q [3];
  logic [3:0]    side_dly;
  logic          vld_out_r;
  logic          ok_r;
  logic signed [31:0] u_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_mag_r <= 1'b0;
      vld_sq_r  <= 1'b0;
      vld_sum_r <= 1'b0;
      vld_out_r <= 1'b0;
    end else if (en) begin
      vld_mag_r <= vld_i;
      vld_sq_r  <= vld_norm;
      vld_sum_r <= vld_sq_r;
      vld_out_r <= vld_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        mag_r[j] <= v_i[j][VW-1] ? VW'(-v_i[j]) : VW'(v_i[j]);
        sgn_r[j] <= v_i[j][VW-1];
        sq_r[j]  <= mn[j] * mn[j];
      end
      zero_r <= (v_i[0] == '0) && (v_i[1] == '0) && (v_i[2] == '0);
      sum_r  <= 64'(sq_r[0]) + 64'(sq_r[1]) + 64'(sq_r[2]);
    end
  end

  lav_norm #(.W(VW)) u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (vld_mag_r),
    .mag_i (mag_r),
    .vld_o (vld_norm),
    .mag_o (mn)
  );

  lav_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (vld_sum_r),
    .x_i    (sum_r),
    .vld_o  (vld_root),
    .root_o (root)
  );

  lav_delay #(.W(93), .D(SQ_LAT + SQRT_LAT)) u_mag_dly (
    .clk (clk),
    .en  (en),
    .d_i ({mn[2], mn[1], mn[0]}),
    .q_o (mn_dly)
  );

  assign mdiv[0] = mn_dly[30:0];
  assign mdiv[1] = mn_dly[61:31];
  assign mdiv[2] = mn_dly[92:62];

  lav_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (vld_root),
    .n_i   (root),
    .m_i   (mdiv),
    .vld_o (vld_q),
    .q_o   (q)
  );

  lav_delay #(.W(4), .D(NORM_LAT + SQ_LAT + SQRT_LAT + DIV_LAT)) u_side_dly (
    .clk (clk),
    .en  (en),
    .d_i ({zero_r, sgn_r}),
    .q_o (side_dly)
  );

  // A zero vector has no direction; its quotients are meaningless and are forced to zero.
  always_ff @(posedge clk) begin
    if (en) begin
      ok_r <= !side_dly[3];
      for (int j = 0; j < 3; j++) begin
        if (side_dly[3]) begin
          u_r[j] <= '0;
        end else if (side_dly[j]) begin
          u_r[j] <= -$signed({1'b0, q[j]});
        end else begin
          u_r[j] <= $signed({1'b0, q[j]});
        end
      end
    end
  end

  assign vld_o = vld_out_r;
  assign ok_o  = ok_r;
  assign u_o   = u_r;

endmodule

// File: rtl/lav_tail.sv
// Back end: true up vector, the three translation dot products and row rounding.
module lav_tail import lav_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic               ok_i,
  input  logic signed [31:0] s_i   [3],
  input  logic signed [31:0] f_i   [3],
  input  logic signed [31:0] eye_i [3],
  output logic               vld_o,
  output mat_t               mat_o
);

  localparam int SH = UNIT_FB - FRAC_BITS;

  logic vld1_r, vld2_r, vld3_r, vld4_r, vld5_r, vld6_r;
  logic ok1_r, ok2_r, ok3_r, ok4_r, ok5_r;

  logic signed [63:0] sf_r [6];
  logic signed [63:0] se_r [3];
  logic signed [63:0] fe_r [3];
  logic signed [31:0] s1_r [3], f1_r [3], eye1_r [3];

  logic signed [63:0] uf_r [3];
  logic signed [65:0] sd_r, fd_r;
  logic signed [31:0] s2_r [3], f2_r [3], eye2_r [3];

  logic signed [32:0] u3_r [3];
  elem_t              sdr3_r, fdr3_r;
  logic signed [31:0] s3_r [3], f3_r [3], eye3_r [3];

  logic signed [65:0] ue_r [3];
  logic signed [32:0] u4_r [3];
  elem_t              sdr4_r, fdr4_r;
  logic signed [31:0] s4_r [3], f4_r [3];

  logic signed [65:0] ud5_r;
  logic signed [32:0] u5_r [3];
  elem_t              sdr5_r, fdr5_r;
  logic signed [31:0] s5_r [3], f5_r [3];

  mat_t mat_nxt;
  mat_t mat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Products for u = s x f and for the dot products with the eye point.
      sf_r[0] <= s_i[1] * f_i[2];
      sf_r[1] <= s_i[2] * f_i[1];
      sf_r[2] <= s_i[2] * f_i[0];
      sf_r[3] <= s_i[0] * f_i[2];
      sf_r[4] <= s_i[0] * f_i[1];
      sf_r[5] <= s_i[1] * f_i[0];
      for (int j = 0; j < 3; j++) begin
        se_r[j] <= s_i[j] * eye_i[j];
        fe_r[j] <= f_i[j] * eye_i[j];
      end
      s1_r   <= s_i;
      f1_r   <= f_i;
      eye1_r <= eye_i;
      ok1_r  <= ok_i;

      for (int j = 0; j < 3; j++) begin
        uf_r[j] <= sf_r[2*j] - sf_r[2*j+1];
      end
      sd_r   <= 66'(se_r[0]) + 66'(se_r[1]) + 66'(se_r[2]);
      fd_r   <= 66'(fe_r[0]) + 66'(fe_r[1]) + 66'(fe_r[2]);
      s2_r   <= s1_r;
      f2_r   <= f1_r;
      eye2_r <= eye1_r;
      ok2_r  <= ok1_r;

      for (int j = 0; j < 3; j++) begin
        u3_r[j] <= 33'(rnd_shift(66'(uf_r[j]), UNIT_FB));
      end
      sdr3_r <= ELEM_W'(rnd_shift(sd_r, UNIT_FB));
      fdr3_r <= ELEM_W'(rnd_shift(fd_r, UNIT_FB));
      s3_r   <= s2_r;
      f3_r   <= f2_r;
      eye3_r <= eye2_r;
      ok3_r  <= ok2_r;

      for (int j = 0; j < 3; j++) begin
        ue_r[j] <= u3_r[j] * eye3_r[j];
      end
      u4_r   <= u3_r;
      sdr4_r <= sdr3_r;
      fdr4_r <= fdr3_r;
      s4_r   <= s3_r;
      f4_r   <= f3_r;
      ok4_r  <= ok3_r;

      ud5_r  <= ue_r[0] + ue_r[1] + ue_r[2];
      u5_r   <= u4_r;
      sdr5_r <= sdr4_r;
      fdr5_r <= fdr4_r;
      s5_r   <= s4_r;
      f5_r   <= f4_r;
      ok5_r  <= ok4_r;

      mat_r  <= mat_nxt;
    end
  end

  always_comb begin
    mat_nxt       = '0;
    mat_nxt.degen = !ok5_r;
    if (ok5_r) begin
      mat_nxt.side.e0 = ELEM_W'(rnd_shift(66'(s5_r[0]), SH));
      mat_nxt.side.e1 = ELEM_W'(rnd_shift(66'(s5_r[1]), SH));
      mat_nxt.side.e2 = ELEM_W'(rnd_shift(66'(s5_r[2]), SH));
      mat_nxt.side.e3 = -sdr5_r;
      mat_nxt.up.e0   = ELEM_W'(rnd_shift(66'(u5_r[0]), SH));
      mat_nxt.up.e1   = ELEM_W'(rnd_shift(66'(u5_r[1]), SH));
      mat_nxt.up.e2   = ELEM_W'(rnd_shift(66'(u5_r[2]), SH));
      mat_nxt.up.e3   = -ELEM_W'(rnd_shift(ud5_r, UNIT_FB));
      mat_nxt.fwd.e0  = -ELEM_W'(rnd_shift(66'(f5_r[0]), SH));
      mat_nxt.fwd.e1  = -ELEM_W'(rnd_shift(66'(f5_r[1]), SH));
      mat_nxt.fwd.e2  = -ELEM_W'(rnd_shift(66'(f5_r[2]), SH));
      mat_nxt.fwd.e3  = fdr5_r;
    end
  end

  assign vld_o = vld6_r;
  assign mat_o = mat_r;

endmodule
